// File: src/canonical_huffman_pixel_decoder_defines.svh
// ----------------------------------------------------------------------------
// Canonical Huffman pixel decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_PIXEL_DECODER_DEFINES_SVH
`define CANONICAL_HUFFMAN_PIXEL_DECODER_DEFINES_SVH

// property must hold at every clock out of reset
`define CHPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define CHPD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/chpd_pkg.sv
// ----------------------------------------------------------------------------
// chpd_pkg
// Constants, codes and types shared by the canonical Huffman pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package chpd_pkg;

    localparam int MAX_SYMBOLS   = 256;
    localparam int COLOR_BITS    = 8;
    localparam int LENGTH_BITS   = 5;
    localparam int MAX_CODE_BITS = 31;
    localparam int CODE_W        = 32;
    localparam int LEN_SLOTS     = 1 << LENGTH_BITS;
    localparam int IDX_W         = $clog2(MAX_SYMBOLS);
    localparam int CNT_W         = $clog2(MAX_SYMBOLS + 1);
    localparam int ENTRY_W       = LENGTH_BITS + 2 * COLOR_BITS;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BIT   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] RK_PIXEL    = 2'd0;
    localparam logic [1:0] RK_NO_MATCH = 2'd1;
    localparam logic [1:0] RK_FULL     = 2'd2;
    localparam logic [1:0] RK_ZERO_LEN = 2'd3;

    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_port_t;

endpackage

`default_nettype wire

// File: src/chpd_ifs.sv
// ----------------------------------------------------------------------------
// Decoder channels
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface chpd_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] entry_red;
    logic [7:0] entry_green_blue;
    logic [4:0] entry_code_length;
    logic       data_bit;

    modport source (output valid, cmd, entry_red, entry_green_blue, entry_code_length,
                    data_bit, input ready);
    modport sink   (input valid, cmd, entry_red, entry_green_blue, entry_code_length,
                    data_bit, output ready);
endinterface

interface chpd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (output valid, result_kind, pixel_red, pixel_green, pixel_blue,
                    input ready);
    modport sink   (input valid, result_kind, pixel_red, pixel_green, pixel_blue,
                    output ready);
endinterface

`default_nettype wire

// File: src/chpd_ram.sv
// ----------------------------------------------------------------------------
// chpd_ram
// Sorted symbol store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module chpd_ram (
    input  logic                        clk,
    input  chpd_pkg::wr_port_t          wr,
    input  logic [chpd_pkg::IDX_W-1:0]  raddr,
    output chpd_pkg::entry_t            rdata
);

    chpd_pkg::entry_t mem [chpd_pkg::MAX_SYMBOLS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/canonical_huffman_pixel_decoder.sv
// ----------------------------------------------------------------------------
// canonical_huffman_pixel_decoder
// Loads a sorted canonical code table and decodes a serial bit stream
// into RGB pixels (green equal to blue).
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  item    | in  | cmd, entry_red, entry_green_blue, entry_code_length, data_bit
//  result  | out | result_kind, pixel_red, pixel_green, pixel_blue
//
//  Data bit: a pixel is staged through one symbol store read before it is
//  emitted; a no-match at the 31-bit limit is emitted directly. Load: a
//  rejected load (zero length or full table) emits a result; into an empty
//  table the entry is written directly, else each stored entry sorting above
//  the new one is shifted up (one store read per shifted entry). Clear and no-op emit nothing.
//  Reset clears table count, length counts and decoder; store contents persist.
//  A held result beat stalls only the next beat that produces a result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "canonical_huffman_pixel_decoder_defines.svh"

module canonical_huffman_pixel_decoder (
    input  logic           clk,
    input  logic           rst_n,
    chpd_item_if.sink      item,
    chpd_result_if.source  result
);

    localparam int CODE_W = chpd_pkg::CODE_W;
    localparam int CNT_W  = chpd_pkg::CNT_W;
    localparam int IDX_W  = chpd_pkg::IDX_W;
    localparam int LEN_W  = chpd_pkg::LENGTH_BITS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_LD_CMP = 6'b000100,
        S_LD_PUT = 6'b001000,
        S_FETCH  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       gb_reg, gb_next;
    logic             bit_reg, bit_next;

    logic [CNT_W-1:0]  loaded_reg, loaded_next;
    logic [CNT_W-1:0]  counts_reg [chpd_pkg::LEN_SLOTS];
    logic [CNT_W-1:0]  counts_next [chpd_pkg::LEN_SLOTS];
    logic [CODE_W-1:0] code_reg, code_next;
    logic [LEN_W-1:0]  bits_reg, bits_next;
    logic [CODE_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;

    logic [1:0] pend_kind_reg, pend_kind_next;
    logic [7:0] pend_red_reg, pend_red_next;
    logic [7:0] pend_gb_reg, pend_gb_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_kind_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_gb_reg;
    logic       out_load;

    chpd_pkg::wr_port_t wr;
    logic [IDX_W-1:0]   raddr;
    chpd_pkg::entry_t   rdata;
    chpd_pkg::entry_t   key;

    logic [CODE_W-1:0] code_shift;
    logic [LEN_W-1:0]  bits_inc;
    logic [CNT_W-1:0]  count_sel;
    logic [CODE_W:0]   diff;
    logic              hit;
    logic [CNT_W-1:0]  idx_sum;
    logic [CODE_W:0]   first_sum;
    logic [CODE_W-1:0] first_adv;
    logic              give_up;
    logic              load_done;
    logic              restart;

    chpd_ram u_ram (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign key = {len_reg, red_reg, gb_reg};

    assign code_shift = {code_reg[CODE_W-2:0], bit_reg};
    assign bits_inc   = bits_reg + 1'b1;
    assign count_sel  = counts_reg[bits_inc];
    assign diff       = {1'b0, code_shift} - {1'b0, first_reg};
    assign hit        = !diff[CODE_W] && (diff[CODE_W-1:0] < CODE_W'(count_sel));
    assign idx_sum    = base_reg + diff[CNT_W-1:0];
    assign first_sum  = {1'b0, first_reg} + (CODE_W+1)'(count_sel);
    assign first_adv  = (first_sum[CODE_W:CODE_W-1] != 2'b00) ? '1
                        : {first_sum[CODE_W-2:0], 1'b0};
    assign give_up    = bits_inc >= LEN_W'(chpd_pkg::MAX_CODE_BITS);

    assign item.ready          = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.pixel_red    = out_red_reg;
    assign result.pixel_green  = out_gb_reg;
    assign result.pixel_blue   = out_gb_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        red_next       = red_reg;
        gb_next        = gb_reg;
        bit_next       = bit_reg;
        loaded_next    = loaded_reg;
        counts_next    = counts_reg;
        code_next      = code_reg;
        bits_next      = bits_reg;
        first_next     = first_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        pend_kind_next = pend_kind_reg;
        pend_red_next  = pend_red_reg;
        pend_gb_next   = pend_gb_reg;
        out_load       = 1'b0;
        wr             = '0;
        raddr          = '0;
        load_done      = 1'b0;
        restart        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    cmd_next   = item.cmd;
                    len_next   = item.entry_code_length;
                    red_next   = item.entry_red;
                    gb_next    = item.entry_green_blue;
                    bit_next   = item.data_bit;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg)
                    chpd_pkg::CMD_LOAD:
                    begin
                        if (len_reg == '0)
                        begin
                            pend_kind_next = chpd_pkg::RK_ZERO_LEN;
                            pend_red_next  = '0;
                            pend_gb_next   = '0;
                            state_next     = S_EMIT;
                        end
                        else if (loaded_reg == CNT_W'(chpd_pkg::MAX_SYMBOLS))
                        begin
                            pend_kind_next = chpd_pkg::RK_FULL;
                            pend_red_next  = '0;
                            pend_gb_next   = '0;
                            state_next     = S_EMIT;
                        end
                        else if (loaded_reg == '0)
                        begin
                            wr.en     = 1'b1;
                            wr.addr   = '0;
                            wr.data   = key;
                            load_done = 1'b1;
                        end
                        else
                        begin
                            pos_next   = IDX_W'(loaded_reg - 1'b1);
                            raddr      = IDX_W'(loaded_reg - 1'b1);
                            state_next = S_LD_CMP;
                        end
                    end
                    chpd_pkg::CMD_BIT:
                    begin
                        if (hit)
                        begin
                            raddr      = idx_sum[IDX_W-1:0];
                            restart    = 1'b1;
                            state_next = S_FETCH;
                        end
                        else if (give_up)
                        begin
                            pend_kind_next = chpd_pkg::RK_NO_MATCH;
                            pend_red_next  = '0;
                            pend_gb_next   = '0;
                            restart        = 1'b1;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            code_next  = code_shift;
                            bits_next  = bits_inc;
                            base_next  = base_reg + count_sel;
                            first_next = first_adv;
                            state_next = S_IDLE;
                        end
                    end
                    chpd_pkg::CMD_CLEAR:
                    begin
                        loaded_next = '0;
                        for (int i = 0; i < chpd_pkg::LEN_SLOTS; i++)
                        begin
                            counts_next[i] = '0;
                        end
                        restart    = 1'b1;
                        state_next = S_IDLE;
                    end
                    chpd_pkg::CMD_NOP:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LD_CMP:
            begin
                wr.en   = 1'b1;
                wr.addr = pos_reg + 1'b1;
                if (rdata > key)
                begin
                    wr.data = rdata;
                    if (pos_reg == '0)
                    begin
                        state_next = S_LD_PUT;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                        raddr    = pos_reg - 1'b1;
                    end
                end
                else
                begin
                    wr.data   = key;
                    load_done = 1'b1;
                end
            end
            S_LD_PUT:
            begin
                wr.en     = 1'b1;
                wr.addr   = '0;
                wr.data   = key;
                load_done = 1'b1;
            end
            S_FETCH:
            begin
                pend_kind_next = chpd_pkg::RK_PIXEL;
                pend_red_next  = rdata[2*chpd_pkg::COLOR_BITS-1:chpd_pkg::COLOR_BITS];
                pend_gb_next   = rdata[chpd_pkg::COLOR_BITS-1:0];
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase

        if (load_done)
        begin
            loaded_next          = loaded_reg + 1'b1;
            counts_next[len_reg] = counts_reg[len_reg] + 1'b1;
            restart              = 1'b1;
            state_next           = S_IDLE;
        end

        if (restart)
        begin
            code_next  = '0;
            bits_next  = '0;
            first_next = '0;
            base_next  = '0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            code_reg      <= '0;
            bits_reg      <= '0;
            first_reg     <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < chpd_pkg::LEN_SLOTS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            code_reg      <= code_next;
            bits_reg      <= bits_next;
            first_reg     <= first_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            counts_reg    <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        len_reg       <= len_next;
        red_reg       <= red_next;
        gb_reg        <= gb_next;
        bit_reg       <= bit_next;
        pos_reg       <= pos_next;
        pend_kind_reg <= pend_kind_next;
        pend_red_reg  <= pend_red_next;
        pend_gb_reg   <= pend_gb_next;
        if (out_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_red_reg  <= pend_red_reg;
            out_gb_reg   <= pend_gb_reg;
        end
    end

    `CHPD_NEVER(a_loaded_bound, loaded_reg > CNT_W'(chpd_pkg::MAX_SYMBOLS),
        "entry count above table size")
    `CHPD_NEVER(a_base_bound, base_reg > loaded_reg,
        "index base past loaded entries")
    `CHPD_ASSERT(a_rise_from_emit, $rose(out_valid_reg) |-> $past(state_reg == S_EMIT),
        "result beat not staged through emit")
    `CHPD_ASSERT(a_bit_advance,
        (state_reg == S_EXEC && cmd_reg == chpd_pkg::CMD_BIT && !hit && !give_up)
        |=> (bits_reg == $past(bits_inc)),
        "partial code length did not advance")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// canonical_huffman_pixel_decoder testbench
// Loads canonical code tables, streams encoded bits and checks every result
// beat against a cycle-free model of the table and the bit decoder. Covers
// zero-length entries, a full table, loads and clears during decoding,
// oversubscribed tables and unmatched streams, then random tables and
// streams, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BEATS = 160;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    chpd_item_if   items_ch ();
    chpd_result_if results_ch ();

    canonical_huffman_pixel_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (items_ch),
        .result (results_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // decoder model state
    chpd_pkg::entry_t table_keys [chpd_pkg::MAX_SYMBOLS];
    int          table_size;
    int          per_len_count [chpd_pkg::LEN_SLOTS];
    logic [31:0] partial_code;
    int          partial_len;
    logic [31:0] len_first_code;
    int          len_base;

    pixel_beat_t awaited_beats [$];
    pixel_beat_t seen_beat;
    pixel_beat_t want_beat;
    int          failures;
    int          beats_sent;
    int          cycle_count;
    int          sender_calm;
    int          receiver_calm;

    function automatic void restart_code();
        partial_code   = '0;
        partial_len    = 0;
        len_first_code = '0;
        len_base       = 0;
    endfunction

    function automatic void empty_table();
        table_size = 0;
        foreach (per_len_count[k])
            per_len_count[k] = 0;
        restart_code();
    endfunction

    // Applies one command beat to the model; returns 1 when it yields a result.
    function automatic bit decode_step(input logic [1:0] op, input logic [7:0] red,
                                       input logic [7:0] green_blue,
                                       input logic [4:0] code_len, input logic bit_in,
                                       output pixel_beat_t beat);
        int               pos;
        int               cnt;
        int               idx;
        logic [31:0]      offset;
        logic [63:0]      nxt;
        chpd_pkg::entry_t key;
        chpd_pkg::entry_t hit;
        beat = '0;
        case (op)
            chpd_pkg::CMD_LOAD:
            begin
                if (code_len == 0)
                begin
                    beat.kind = chpd_pkg::RK_ZERO_LEN;
                    return 1'b1;
                end
                if (table_size >= chpd_pkg::MAX_SYMBOLS)
                begin
                    beat.kind = chpd_pkg::RK_FULL;
                    return 1'b1;
                end
                key = {code_len, red, green_blue};
                pos = 0;
                while (pos < table_size && table_keys[pos] <= key)
                    pos++;
                for (int k = table_size; k > pos; k--)
                    table_keys[k] = table_keys[k - 1];
                table_keys[pos] = key;
                table_size++;
                per_len_count[code_len]++;
                restart_code();
                return 1'b0;
            end
            chpd_pkg::CMD_BIT:
            begin
                partial_code = {partial_code[30:0], bit_in};
                partial_len++;
                cnt = per_len_count[partial_len % chpd_pkg::LEN_SLOTS];
                offset = partial_code - len_first_code;
                if (partial_code >= len_first_code && offset < 32'(cnt))
                begin
                    idx = len_base + int'(offset);
                    hit = (idx < chpd_pkg::MAX_SYMBOLS) ? table_keys[idx] : '0;
                    restart_code();
                    beat.kind  = chpd_pkg::RK_PIXEL;
                    beat.red   = hit[15:8];
                    beat.green = hit[7:0];
                    beat.blue  = hit[7:0];
                    return 1'b1;
                end
                if (partial_len >= chpd_pkg::MAX_CODE_BITS)
                begin
                    restart_code();
                    beat.kind = chpd_pkg::RK_NO_MATCH;
                    return 1'b1;
                end
                len_base += cnt;
                nxt = (64'(len_first_code) + 64'(cnt)) << 1;
                len_first_code = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
                return 1'b0;
            end
            chpd_pkg::CMD_CLEAR:
            begin
                empty_table();
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Canonical code of table entry idx; 0 when the code cannot fit its length.
    function automatic bit symbol_code(input int idx, output int clen,
                                       output logic [31:0] code);
        logic [63:0] first;
        int          base;
        first = '0;
        base  = 0;
        clen  = 0;
        code  = '0;
        for (int l = 1; l < chpd_pkg::LEN_SLOTS; l++)
        begin
            if (idx < base + per_len_count[l])
            begin
                first = first + 64'(idx - base);
                clen  = l;
                code  = first[31:0];
                return first < (64'd1 << l);
            end
            base += per_len_count[l];
            first = (first + 64'(per_len_count[l])) << 1;
        end
        return 1'b0;
    endfunction

    function automatic int idle_cycles(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            calm_left = $urandom_range(8, 40);
        return $urandom_range(0, 17);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] seen);
        if (seen !== want)
        begin
            failures++;
            if (failures <= 100)
                $display("%0t ns: %s expected %0h, got %0h", $time, name, want, seen);
        end
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [7:0] red,
                             input logic [7:0] green_blue, input logic [4:0] code_len,
                             input logic bit_in);
        int          gap;
        pixel_beat_t beat;
        gap = idle_cycles(sender_calm);
        if (gap > 0)
        begin
            items_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        items_ch.cmd               = op;
        items_ch.entry_red         = red;
        items_ch.entry_green_blue  = green_blue;
        items_ch.entry_code_length = code_len;
        items_ch.data_bit          = bit_in;
        items_ch.valid             = 1'b1;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        if (decode_step(op, red, green_blue, code_len, bit_in, beat))
            awaited_beats = {awaited_beats, beat};
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_bit(input logic bit_in);
        send_beat(chpd_pkg::CMD_BIT, 8'($urandom), 8'($urandom), 5'($urandom), bit_in);
    endtask

    task automatic send_load(input logic [7:0] red, input logic [7:0] green_blue,
                             input logic [4:0] code_len);
        send_beat(chpd_pkg::CMD_LOAD, red, green_blue, code_len, 1'($urandom));
    endtask

    task automatic send_cmd(input logic [1:0] op);
        send_beat(op, 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic send_symbol(input int idx);
        int          clen;
        logic [31:0] code;
        if (symbol_code(idx, clen, code))
        begin
            for (int k = clen - 1; k >= 0; k--)
                send_bit(code[k]);
        end
        else
            send_bit(1'($urandom));
    endtask

    task automatic wait_all_results();
        items_ch.valid = 1'b0;
        while (awaited_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_special_cases();
        // empty table: nothing matches within 31 bits
        repeat (chpd_pkg::MAX_CODE_BITS) send_bit(1'($urandom));
        send_load(8'hFF, 8'hFF, 5'd0);
        send_load(8'hFF, 8'h00, 5'd1);
        send_load(8'h00, 8'hFF, 5'd31);
        send_symbol(0);
        send_symbol(1);
        // NOP and zero-length load keep the partial code
        send_bit(1'b1);
        send_cmd(chpd_pkg::CMD_NOP);
        send_load(8'h00, 8'h00, 5'd0);
        repeat (chpd_pkg::MAX_CODE_BITS - 1) send_bit(1'b0);
        // load mid-code restarts the decoder
        send_bit(1'b1);
        send_load(8'h80, 8'h7F, 5'd2);
        send_symbol(1);
        // three 1-bit codes: the last one can never match
        send_load(8'h00, 8'h00, 5'd1);
        send_load(8'h01, 8'h01, 5'd1);
        send_bit(1'b1);
        send_bit(1'b0);
        wait_all_results();
        send_bit(1'b1);
        send_cmd(chpd_pkg::CMD_CLEAR);
        repeat (chpd_pkg::MAX_CODE_BITS) send_bit(1'($urandom));
    endtask

    task automatic test_table_full();
        send_cmd(chpd_pkg::CMD_CLEAR);
        for (int k = 0; k < chpd_pkg::MAX_SYMBOLS; k++)
            send_load(8'(k), 8'($urandom), 5'd8);
        send_load(8'($urandom), 8'($urandom), 5'($urandom_range(1, 31)));
        send_load(8'($urandom), 8'($urandom), 5'd0);
        repeat (6) send_symbol($urandom_range(0, chpd_pkg::MAX_SYMBOLS - 1));
        wait_all_results();
        repeat (6) send_symbol($urandom_range(0, chpd_pkg::MAX_SYMBOLS - 1));
        send_cmd(chpd_pkg::CMD_CLEAR);
    endtask

    task automatic test_random_streams();
        int     start;
        int     n_entries;
        int     l;
        int     lmin;
        longint room;
        bit     loose;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 3) != 0)
                send_cmd(chpd_pkg::CMD_CLEAR);
            // mostly prefix-free tables, sometimes oversubscribed ones
            loose     = ($urandom_range(0, 5) == 0);
            room      = longint'(1) << chpd_pkg::MAX_CODE_BITS;
            n_entries = $urandom_range(1, 12);
            for (int k = 0; k < n_entries; k++)
            begin
                if (loose)
                    l = $urandom_range(1, 6);
                else
                begin
                    l = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 31)
                                                    : $urandom_range(1, 8);
                    lmin = 1;
                    while (lmin <= chpd_pkg::MAX_CODE_BITS &&
                           (longint'(1) << (chpd_pkg::MAX_CODE_BITS - lmin)) > room)
                        lmin++;
                    if (lmin > chpd_pkg::MAX_CODE_BITS)
                        break;
                    if (l < lmin)
                        l = lmin;
                    room -= longint'(1) << (chpd_pkg::MAX_CODE_BITS - l);
                end
                send_load(8'($urandom), 8'($urandom), 5'(l));
                if ($urandom_range(0, 15) == 0)
                    send_load(8'($urandom), 8'($urandom), 5'd0);
            end
            repeat ($urandom_range(3, 14))
            begin
                case ($urandom_range(0, 19))
                    0: send_bit(1'($urandom));
                    1: send_cmd(chpd_pkg::CMD_NOP);
                    2: send_load(8'($urandom), 8'($urandom), 5'd0);
                    3: send_load(8'($urandom), 8'($urandom), 5'($urandom_range(1, 31)));
                    4: send_cmd(chpd_pkg::CMD_CLEAR);
                    default:
                    begin
                        if (table_size > 0)
                            send_symbol($urandom_range(0, table_size - 1));
                        else
                            send_bit(1'($urandom));
                    end
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                wait_all_results();
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("canonical_huffman_pixel_decoder regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            seen_beat = {results_ch.result_kind, results_ch.pixel_red,
                         results_ch.pixel_green, results_ch.pixel_blue};
            if (awaited_beats.size() == 0)
            begin
                failures++;
                $display("%0t ns: result beat with none expected, got %p", $time, seen_beat);
            end
            else
            begin
                want_beat = awaited_beats.pop_front();
                check_field("result_kind", 8'(want_beat.kind), 8'(seen_beat.kind));
                check_field("pixel_red", want_beat.red, seen_beat.red);
                check_field("pixel_green", want_beat.green, seen_beat.green);
                check_field("pixel_blue", want_beat.blue, seen_beat.blue);
            end
        end
    end

    // result sink: random stall before each beat
    initial
    begin
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            results_ch.ready = 1'b0;
            repeat (idle_cycles(receiver_calm)) @(negedge clk);
            results_ch.ready = 1'b1;
            @(posedge clk);
            while (!results_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n                      = 1'b0;
        items_ch.valid             = 1'b0;
        items_ch.cmd               = chpd_pkg::CMD_NOP;
        items_ch.entry_red         = '0;
        items_ch.entry_green_blue  = '0;
        items_ch.entry_code_length = '0;
        items_ch.data_bit          = 1'b0;
        failures                   = 0;
        beats_sent                 = 0;
        cycle_count                = 0;
        sender_calm                = 0;
        receiver_calm              = 0;
        empty_table();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_table_full();
        test_random_streams();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("canonical_huffman_pixel_decoder regression: pass");
        else
            $display("canonical_huffman_pixel_decoder regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/chpd_pkg.sv
src/chpd_ifs.sv
src/chpd_ram.sv
src/canonical_huffman_pixel_decoder.sv
tb/sv/tb.sv
